[rtl/core/vrp_pkg.sv]
package vrp_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int FRACTION_BITS   = 12;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE    = 3'd0,
		CFG_ASPECT   = 3'd1,
		CFG_CAM_DIST = 3'd2,
		CFG_SCALE    = 3'd3,
		CFG_CENTER_X = 3'd4,
		CFG_CENTER_Y = 3'd5
	} cfg_idx_t;

	localparam logic [15:0] RST_ANGLE    = 16'd0;
	localparam logic [14:0] RST_ASPECT   = 15'd4096;
	localparam logic [14:0] RST_CAM_DIST = 15'd16384;
	localparam logic [11:0] RST_SCALE    = 12'd300;
	localparam logic [11:0] RST_CENTER_X = 12'd320;
	localparam logic [11:0] RST_CENTER_Y = 12'd240;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	// near clamp, 0.001 in Q3.12
	localparam logic [17:0] ZMIN_Q12 = 18'd4;
	localparam logic signed [15:0] DEPTH_BIAS = 16'sd2048;
	// v/20 = (v * DIV20_MUL) >> DIV20_SHIFT, low by at most one
	localparam logic [18:0] DIV20_MUL   = 19'd419430;
	localparam int          DIV20_SHIFT = 23;
	localparam logic [17:0] DIV20_DEN   = 18'd20;
	localparam logic [17:0] DIV20_TIE   = 18'd10;

	// quotient bits kept by the divider chains; one more cell flags overflow
	localparam int QUOT_BITS = 24;
	localparam logic [23:0] SAT24 = 24'hFF_FFFF;
	// numerators already doubled for round-to-nearest
	localparam logic [29:0] RECIP_ONE_NUM = 30'd1 << 29;
	localparam logic [33:0] RECIP_SCL_NUM = 34'(64'd6553 << 21);
	localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [7:0]         color_r;
		logic [7:0]         color_g;
		logic [7:0]         color_b;
	} vrp_in_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic signed [15:0] depth_value;
		logic [23:0]        inverse_depth;
		logic [23:0]        scaled_inverse_depth;
		logic [7:0]         out_r;
		logic [7:0]         out_g;
		logic [7:0]         out_b;
		logic [7:0]         out_alpha;
	} vrp_out_t;

	// quarter-wave sine entry, Q30 Taylor series, rounded to fb fraction bits
	function automatic logic [63:0] rom_entry(input int unsigned i, input int unsigned tb,
			input int unsigned fb);
		logic [63:0] n;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		n  = 64'd1 << tb;
		x  = (PI_HALF_Q30 * 64'(i) + (n >> 1)) >> tb;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		return (s + (64'd1 << (29 - fb))) >> (30 - fb);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
		if (v > 27'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -27'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

[rtl/core/vrp_stream_if.sv]
interface vrp_stream_if #(parameter type T = vrp_pkg::vrp_in_t);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/vrp_sine_rom.sv]
module vrp_sine_rom #(
	parameter int SINE_TABLE_BITS = vrp_pkg::SINE_TABLE_BITS,
	parameter int FRACTION_BITS   = vrp_pkg::FRACTION_BITS
) (
	input  logic                            clk,
	input  logic [15:0]                     angle,
	output logic signed [FRACTION_BITS+1:0] sin_q,
	output logic signed [FRACTION_BITS+1:0] cos_q
);
	localparam int TB = SINE_TABLE_BITS;
	localparam int F  = FRACTION_BITS;
	localparam logic [TB:0] NFULL = (TB+1)'(1) << TB;

	logic [F:0]  tbl [0:(1 << TB)];
	logic [15:0] cos_angle;

	for (genvar g = 0; g <= (1 << TB); g++) begin : g_tbl
		assign tbl[g] = (F+1)'(vrp_pkg::rom_entry(g, TB, F));
	end

	assign cos_angle = angle + 16'h4000;

	// quadrant fold: odd quadrants mirror the index, upper half negates
	function automatic logic signed [F+1:0] lookup(input logic [15:0] a);
		logic [TB:0] idx;
		logic [F:0]  mag;
		idx = {1'b0, a[13:14-TB]};
		if (a[14]) begin
			idx = NFULL - idx;
		end
		mag = tbl[idx];
		return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	always_ff @(posedge clk) begin
		sin_q <= lookup(angle);
		cos_q <= lookup(cos_angle);
	end
endmodule

[rtl/core/vrp_div_cell.sv]
module vrp_div_cell #(
	parameter int NW = 36,
	parameter int DW = 19,
	parameter int SH = 0,
	parameter int QW = 25,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] rem_i,
	input  logic [DW-1:0] den_i,
	input  logic [QW-1:0] quo_i,
	input  logic [SW-1:0] side_i,
	output logic [NW-1:0] rem_q,
	output logic [DW-1:0] den_q,
	output logic [QW-1:0] quo_q,
	output logic [SW-1:0] side_q
);
	localparam int CW = ((NW > DW + SH) ? NW : DW + SH) + 1;

	logic [CW-1:0] rem_w;
	logic [CW-1:0] den_w;
	logic [CW-1:0] diff;
	logic          ge;
	logic [QW-1:0] quo_nxt;

	// one restoring step: try the divisor at weight 2^SH
	always_comb begin
		rem_w   = CW'(rem_i);
		den_w   = CW'(den_i) << SH;
		ge      = rem_w >= den_w;
		diff    = rem_w - den_w;
		quo_nxt = quo_i;
		quo_nxt[SH] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[NW-1:0] : rem_i;
			den_q  <= den_i;
			quo_q  <= quo_nxt;
			side_q <= side_i;
		end
	end
endmodule

[rtl/core/vrp_div_chain.sv]
module vrp_div_chain #(
	parameter int NW = 36,
	parameter int DW = 19,
	parameter int QB = vrp_pkg::QUOT_BITS,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_i,
	output logic [QB:0]   quo,
	output logic [SW-1:0] side_o
);
	// QB+1 cells, top cell flags a quotient that does not fit in QB bits
	logic [NW-1:0] rem_w  [0:QB+1];
	logic [DW-1:0] den_w  [0:QB+1];
	logic [QB:0]   quo_w  [0:QB+1];
	logic [SW-1:0] side_w [0:QB+1];

	assign rem_w[0]  = num;
	assign den_w[0]  = den;
	assign quo_w[0]  = '0;
	assign side_w[0] = side_i;

	for (genvar g = 0; g <= QB; g++) begin : g_cell
		vrp_div_cell #(
			.NW(NW), .DW(DW), .SH(QB - g), .QW(QB + 1), .SW(SW)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (rem_w[g]),
			.den_i  (den_w[g]),
			.quo_i  (quo_w[g]),
			.side_i (side_w[g]),
			.rem_q  (rem_w[g+1]),
			.den_q  (den_w[g+1]),
			.quo_q  (quo_w[g+1]),
			.side_q (side_w[g+1])
		);
	end

	assign quo    = quo_w[QB+1];
	assign side_o = side_w[QB+1];
endmodule

[rtl/core/vertex_rotate_project.sv]
// Channel   | Dir | Payload            | Handshake
// ----------+-----+--------------------+-------------------------------
// vtx_in    | in  | vrp_pkg::vrp_in_t  | valid/ready, request on both high
// vtx_out   | out | vrp_pkg::vrp_out_t | valid/ready, request on both high
// cfg_*     | in  | index + 16b data   | write on cfg_we, no stall
//
// One vertex per cycle sustained while vtx_out.ready is high. The pipe is 5 setup
// stages, QUOT_BITS+1 divider cells (25 by default) and the output register.
// The four quotients run in parallel rows of one-bit restoring cells.
// arst_n clears valid bits and loads register defaults; data is not reset.
// The whole pipe advances together; it holds only while a result sits in
// the output register and vtx_out.ready is low.
// Sine/cosine are re-read from the ROM each cycle and follow the angle
// register in the next cycle.
module vertex_rotate_project #(
	parameter int SINE_TABLE_BITS = vrp_pkg::SINE_TABLE_BITS,
	parameter int FRACTION_BITS   = vrp_pkg::FRACTION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vrp_stream_if.sink                      vtx_in,
	vrp_stream_if.source                    vtx_out,
	input  logic                            cfg_we,
	input  logic [vrp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [vrp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	localparam int F  = FRACTION_BITS;
	localparam int SW = F + 2;          // signed sine width
	localparam int PW = 16 + SW;        // coordinate x sine product
	localparam int QB = vrp_pkg::QUOT_BITS;
	localparam logic signed [PW:0] HALF = (PW+1)'(1) << (F - 1);

	// configuration registers
	logic [15:0] angle_q;
	logic [14:0] aspect_q;
	logic [14:0] cam_dist_q;
	logic [11:0] scale_q;
	logic [11:0] center_x_q;
	logic [11:0] center_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q    <= vrp_pkg::RST_ANGLE;
			aspect_q   <= vrp_pkg::RST_ASPECT;
			cam_dist_q <= vrp_pkg::RST_CAM_DIST;
			scale_q    <= vrp_pkg::RST_SCALE;
			center_x_q <= vrp_pkg::RST_CENTER_X;
			center_y_q <= vrp_pkg::RST_CENTER_Y;
		end else if (cfg_we) begin
			case (cfg_idx)
				vrp_pkg::CFG_ANGLE:    angle_q    <= cfg_data[15:0];
				vrp_pkg::CFG_ASPECT:   aspect_q   <= cfg_data[14:0];
				vrp_pkg::CFG_CAM_DIST: cam_dist_q <= cfg_data[14:0];
				vrp_pkg::CFG_SCALE:    scale_q    <= cfg_data[11:0];
				vrp_pkg::CFG_CENTER_X: center_x_q <= cfg_data[11:0];
				vrp_pkg::CFG_CENTER_Y: center_y_q <= cfg_data[11:0];
				default: ;             // unknown index: dropped
			endcase
		end
	end

	logic signed [SW-1:0] sin_q;
	logic signed [SW-1:0] cos_q;

	vrp_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS), .FRACTION_BITS(FRACTION_BITS)
	) u_rom (
		.clk   (clk),
		.angle (angle_q),
		.sin_q (sin_q),
		.cos_q (cos_q)
	);

	// global advance: only a full, unaccepted output register stalls
	logic           en;
	logic           out_v_q;
	vrp_pkg::vrp_out_t out_q;

	assign en           = !out_v_q || vtx_out.ready;
	assign vtx_in.ready = en;

	// valid line through the setup stages and the divider cells
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [QB:0] vc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			vc_q    <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= vtx_in.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			vc_q    <= {vc_q[QB-1:0], v_s5};
			out_v_q <= vc_q[QB];
		end
	end

	// s1: capture vertex
	logic signed [15:0] x_s1, y_s1, z_s1;
	logic [23:0]        col_s1;
	// s2: rotation products, y * aspect
	logic signed [PW-1:0] cx_s2, sz_s2, cz_s2, sx_s2;
	logic signed [31:0]   ya_s2;
	logic [23:0]          col_s2;
	// s3: rounded rotation
	logic signed [17:0] rx_s3, rz_s3;
	logic signed [31:0] ya_s3;
	logic [23:0]        col_s3;
	// s4: scaled numerators, clamped divisor, depth multiply by the reciprocal of 20
	logic signed [30:0] nx_s4;
	logic signed [44:0] ny_s4;
	logic [17:0]        zc_s4;
	logic [17:0]        dv_s4;
	logic [36:0]        dm_s4;
	logic               rzneg_s4;
	logic [23:0]        col_s4;
	// s5: divider operands and depth
	logic [35:0]        xn_s5;
	logic [18:0]        xd_s5;
	logic [48:0]        yn_s5;
	logic [30:0]        yd_s5;
	logic               sgnx_s5, sgny_s5;
	logic signed [15:0] depth_s5;
	logic [23:0]        col_s5;

	logic signed [PW:0]  rxa, rza;
	logic signed [18:0]  zc_raw;
	logic [16:0]         rz_abs;
	logic [30:0]         nxa;
	logic [43:0]         nya;
	logic [13:0]         dq0, dq;
	logic [17:0]         drem;
	logic signed [15:0]  depth_nxt;

	always_comb begin
		rxa    = PW'(cx_s2) + PW'(sz_s2) + HALF;
		rza    = PW'(cz_s2) - PW'(sx_s2) + HALF;
		zc_raw = 19'(rz_s3) + $signed({4'b0, cam_dist_q});
		rz_abs = rz_s3[17] ? 17'(-rz_s3) : 17'(rz_s3);
		nxa    = nx_s4[30] ? 31'(-nx_s4) : 31'(nx_s4);
		nya    = ny_s4[44] ? 44'(-ny_s4) : 44'(ny_s4);
		// rz/10 rounded = floor((2|rz| + 10) / 20), fixed up by one at most
		dq0    = dm_s4[36:vrp_pkg::DIV20_SHIFT];
		drem   = dv_s4 - (18'({dq0, 4'b0}) + 18'({dq0, 2'b0}));
		dq     = (drem >= vrp_pkg::DIV20_DEN) ? dq0 + 14'd1 : dq0;
		// stays inside 16 bits for every rz, so no clamp here
		depth_nxt = vrp_pkg::DEPTH_BIAS + (rzneg_s4 ? -$signed({2'b0, dq})
			: $signed({2'b0, dq}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= vtx_in.data.pos_x;
			y_s1   <= vtx_in.data.pos_y;
			z_s1   <= vtx_in.data.pos_z;
			col_s1 <= {vtx_in.data.color_r, vtx_in.data.color_g, vtx_in.data.color_b};

			cx_s2  <= x_s1 * cos_q;
			sz_s2  <= z_s1 * sin_q;
			cz_s2  <= z_s1 * cos_q;
			sx_s2  <= x_s1 * sin_q;
			ya_s2  <= y_s1 * $signed({1'b0, aspect_q});
			col_s2 <= col_s1;

			// arithmetic shift = floor, matching round-half-up
			rx_s3  <= rxa[F+17:F];
			rz_s3  <= rza[F+17:F];
			ya_s3  <= ya_s2;
			col_s3 <= col_s2;

			nx_s4    <= rx_s3 * $signed({1'b0, scale_q});
			ny_s4    <= ya_s3 * $signed({1'b0, scale_q});
			zc_s4    <= (zc_raw < $signed({1'b0, vrp_pkg::ZMIN_Q12})) ? vrp_pkg::ZMIN_Q12
				: zc_raw[17:0];
			dv_s4    <= {rz_abs, 1'b0} + vrp_pkg::DIV20_TIE;
			dm_s4    <= ({rz_abs, 1'b0} + vrp_pkg::DIV20_TIE) * vrp_pkg::DIV20_MUL;
			rzneg_s4 <= rz_s3[17];
			col_s4   <= col_s3;

			// round to nearest: (2|n| + d) / 2d
			xn_s5    <= {nxa, 5'b0} + 36'(zc_s4);
			xd_s5    <= {zc_s4, 1'b0};
			yn_s5    <= 49'({nya, 5'b0}) + 49'({zc_s4, 12'b0});
			yd_s5    <= {zc_s4, 13'b0};
			sgnx_s5  <= nx_s4[30];
			sgny_s5  <= ny_s4[44];
			depth_s5 <= depth_nxt;
			col_s5   <= col_s4;
		end
	end

	// reciprocal operands; a depth that is not positive is flagged and saturated
	logic        dpos;
	logic [29:0] in_num;
	logic [33:0] sn_num;
	logic [15:0] rd_den;

	assign dpos   = !depth_s5[15] && (depth_s5 != 16'sd0);
	assign in_num = vrp_pkg::RECIP_ONE_NUM + 30'(depth_s5[14:0]);
	assign sn_num = vrp_pkg::RECIP_SCL_NUM + 34'(depth_s5[14:0]);
	assign rd_den = {depth_s5[14:0], 1'b0};

	logic [QB:0]  qx, qy, qi, qs;
	logic [24:0]  xside;
	logic         sgny_c;
	logic [16:0]  iside;
	logic         dpos_s;

	vrp_div_chain #(.NW(36), .DW(19), .QB(QB), .SW(25)) u_div_x (
		.clk(clk), .en(en), .num(xn_s5), .den(xd_s5),
		.side_i({sgnx_s5, col_s5}), .quo(qx), .side_o(xside)
	);

	vrp_div_chain #(.NW(49), .DW(31), .QB(QB), .SW(1)) u_div_y (
		.clk(clk), .en(en), .num(yn_s5), .den(yd_s5),
		.side_i(sgny_s5), .quo(qy), .side_o(sgny_c)
	);

	vrp_div_chain #(.NW(30), .DW(16), .QB(QB), .SW(17)) u_div_inv (
		.clk(clk), .en(en), .num(in_num), .den(rd_den),
		.side_i({dpos, depth_s5}), .quo(qi), .side_o(iside)
	);

	vrp_div_chain #(.NW(34), .DW(16), .QB(QB), .SW(1)) u_div_scl (
		.clk(clk), .en(en), .num(sn_num), .den(rd_den),
		.side_i(dpos), .quo(qs), .side_o(dpos_s)
	);

	// output stage: sign, center offset, saturation
	logic [QB-1:0]      mx, my;
	logic signed [26:0] sx27, sy27;
	vrp_pkg::vrp_out_t  out_nxt;

	always_comb begin
		mx   = qx[QB] ? vrp_pkg::SAT24 : qx[QB-1:0];
		my   = qy[QB] ? vrp_pkg::SAT24 : qy[QB-1:0];
		sx27 = (xside[24] ? -$signed({3'b0, mx}) : $signed({3'b0, mx}))
			+ $signed({11'b0, center_x_q, 4'b0});
		sy27 = (sgny_c ? -$signed({3'b0, my}) : $signed({3'b0, my}))
			+ $signed({11'b0, center_y_q, 4'b0});
		out_nxt.screen_x    = vrp_pkg::sat16(sx27);
		out_nxt.screen_y    = vrp_pkg::sat16(sy27);
		out_nxt.depth_value = iside[15:0];
		out_nxt.inverse_depth = (!iside[16] || qi[QB]) ? vrp_pkg::SAT24 : qi[QB-1:0];
		out_nxt.scaled_inverse_depth = (!dpos_s || qs[QB]) ? vrp_pkg::SAT24
			: qs[QB-1:0];
		out_nxt.out_r     = xside[23:16];
		out_nxt.out_g     = xside[15:8];
		out_nxt.out_b     = xside[7:0];
		out_nxt.out_alpha = vrp_pkg::ALPHA_OPAQUE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_nxt;
		end
	end

	assign vtx_out.valid = out_v_q;
	assign vtx_out.data  = out_q;

	// a held result must block new requests
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !vtx_out.ready) |-> !vtx_in.ready)
		else $error("input taken while output stalled");

	// an accepted request enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_in.valid && vtx_in.ready) |=> v_s1)
		else $error("accepted request lost at stage 1");

	// non-positive depth always gives saturated reciprocals
	a_depth_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (out_q.depth_value <= 16'sd0)) |->
		(out_q.inverse_depth == vrp_pkg::SAT24 &&
		 out_q.scaled_inverse_depth == vrp_pkg::SAT24))
		else $error("reciprocal not saturated for non-positive depth");
endmodule
